>>> hdl/prfa_pkg.sv
// package: sizes, state encoding and table entry type for the page region allocator
`timescale 1ns / 1ps
`default_nettype none
package prfa_pkg;
  localparam int MAX_REGIONS = 64;
  localparam int PAGE_BYTES = 4096;
  localparam int ADDR_BITS = 48;

  localparam int PAGE_W = 36;
  localparam int TYPE_W = 4;
  localparam int MODE_W = 2;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 1;
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int PN_BITS = ADDR_BITS - PAGE_SHIFT;
  localparam int IDX_BITS = $clog2(MAX_REGIONS);
  localparam int CNT_BITS = $clog2(MAX_REGIONS + 1);
  localparam int ENTRY_W = PN_BITS + PAGE_W;

  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ADD = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FIT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;
  localparam logic [STATUS_W-1:0] ST_SKIP = 2'd3;

  localparam logic [TYPE_W-1:0] TYPE_USABLE_A = 4'd3;
  localparam logic [TYPE_W-1:0] TYPE_USABLE_B = 4'd4;
  localparam logic [TYPE_W-1:0] TYPE_USABLE_C = 4'd7;

  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 1'd1;

  localparam logic [ADDR_BITS-1:0] FLOOR_RESET = ADDR_BITS'(64'h100000);
  localparam logic [ADDR_BITS-1:0] LIMIT_RESET = ADDR_BITS'(64'h100000000);

  typedef struct packed {
    logic [PN_BITS-1:0] base;
    logic [PAGE_W-1:0] pages;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_ADD1, S_ADD2, S_ADD3, S_ADD4, S_SRCH, S_AWR, S_TIDY, S_DONE
  } state_t;
endpackage
`default_nettype wire

>>> hdl/prfa_ifs.sv
// channel interfaces for requests and responses
`timescale 1ns / 1ps
`default_nettype none
interface prfa_req_if;
  import prfa_pkg::*;
  logic valid;
  logic ready;
  logic [MODE_W-1:0] mode;
  logic [ADDR_BITS-1:0] region_start;
  logic [ADDR_BITS-1:0] region_end;
  logic [TYPE_W-1:0] region_type;
  logic [PAGE_W-1:0] page_request;
  modport source (output valid, mode, region_start, region_end, region_type, page_request,
                  input ready);
  modport sink (input valid, mode, region_start, region_end, region_type, page_request,
                output ready);
endinterface

interface prfa_rsp_if;
  import prfa_pkg::*;
  logic valid;
  logic ready;
  logic [STATUS_W-1:0] status;
  logic [ADDR_BITS-1:0] alloc_address;
  logic [PAGE_W-1:0] pages_added;
  modport source (output valid, status, alloc_address, pages_added, input ready);
  modport sink (input valid, status, alloc_address, pages_added, output ready);
endinterface
`default_nettype wire

>>> hdl/prfa_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module prfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> hdl/page_region_first_fit_allocator_core.sv
// top level: first-fit page region allocator with sequencer and region table
// table passes: add runs one tidy pass; allocate runs a search pass and then a tidy pass,
//   each reading one table entry per cycle through the single ram read port
// throughput: one transfer at a time, next request taken once the sequencer is idle
// reset: region count goes to zero, floor 0x100000, limit 0x100000000; table contents
//   stay undefined and are never read beyond the count, so no clearing pass
`timescale 1ns / 1ps
`default_nettype none
module page_region_first_fit_allocator_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  prfa_req_if.sink                            req,
  prfa_rsp_if.source                          rsp,
  input  wire logic                           cfg_we,
  input  wire logic [prfa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [prfa_pkg::ADDR_BITS-1:0] cfg_data
);
  import prfa_pkg::*;

  localparam logic [ADDR_BITS-1:0] LOW_MASK = ADDR_BITS'((64'd1 << PAGE_SHIFT) - 64'd1);

  // config registers
  logic [ADDR_BITS-1:0] floor_r, limit_r;

  // latched request
  logic [MODE_W-1:0] op_mode;
  logic [ADDR_BITS-1:0] op_start, op_end;
  logic [TYPE_W-1:0] op_type;
  logic [PAGE_W-1:0] op_nr;

  // sequencer registers
  state_t state, state_next;
  logic [CNT_BITS-1:0] count, count_next;
  logic [CNT_BITS-1:0] rd, rd_next;
  logic [CNT_BITS-1:0] wp, wp_next;
  logic dv, dv_next;
  logic have, have_next;
  entry_t acc, acc_next;
  entry_t hit, hit_next;
  logic [IDX_BITS-1:0] hit_idx, hit_idx_next;
  logic [ADDR_BITS-1:0] a_base, a_base_next;
  logic [ADDR_BITS-1:0] a_next, a_next_next;
  logic [PN_BITS:0] q, q_next;
  logic [STATUS_W-1:0] res_status, res_status_next;
  logic [ADDR_BITS-1:0] res_addr, res_addr_next;
  logic [PAGE_W-1:0] res_pages, res_pages_next;

  // output register
  logic out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [ADDR_BITS-1:0] out_addr;
  logic [PAGE_W-1:0] out_pages;
  logic load_out;

  // table ram port signals
  logic ram_we;
  logic [IDX_BITS-1:0] ram_waddr, ram_raddr;
  entry_t ram_wdata, ram_rdata;
  logic [ENTRY_W-1:0] rdata_raw;

  // combinational unit results
  logic [PN_BITS-1:0] acc_end;
  logic [PAGE_W:0] merge_sum;
  logic [ADDR_BITS-1:0] span;

  assign ram_rdata = entry_t'(rdata_raw);

  prfa_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_REGIONS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rdata_raw)
  );

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.status = out_status;
  assign rsp.alloc_address = out_addr;
  assign rsp.pages_added = out_pages;

  // end of accumulated region in page units, wraps with the address space
  assign acc_end = acc.base + PN_BITS'(acc.pages);
  assign merge_sum = {1'b0, acc.pages} + {1'b0, ram_rdata.pages};
  assign span = a_next - a_base;

  always_comb begin
    state_next = state;
    count_next = count;
    rd_next = rd;
    wp_next = wp;
    dv_next = 1'b0;
    have_next = have;
    acc_next = acc;
    hit_next = hit;
    hit_idx_next = hit_idx;
    a_base_next = a_base;
    a_next_next = a_next;
    q_next = q;
    res_status_next = res_status;
    res_addr_next = res_addr;
    res_pages_next = res_pages;
    ram_we = 1'b0;
    ram_waddr = wp[IDX_BITS-1:0];
    ram_wdata = acc;
    ram_raddr = rd[IDX_BITS-1:0];
    load_out = 1'b0;

    case (state)
      S_IDLE: begin
        if (req.valid) begin
          res_status_next = ST_DONE;
          res_addr_next = '0;
          res_pages_next = '0;
          rd_next = '0;
          case (req.mode)
            MODE_CLEAR: begin
              count_next = '0;
              state_next = S_DONE;
            end
            MODE_ADD: state_next = S_ADD1;
            MODE_ALLOC: state_next = S_SRCH;
            default: begin
              res_status_next = ST_SKIP;
              state_next = S_DONE;
            end
          endcase
        end
      end

      // clamp both ends to the reserved floor, reject unusable types
      S_ADD1: begin
        if (op_type != TYPE_USABLE_A && op_type != TYPE_USABLE_B &&
            op_type != TYPE_USABLE_C) begin
          res_status_next = ST_SKIP;
          state_next = S_DONE;
        end else begin
          a_base_next = (op_start < floor_r) ? floor_r : op_start;
          a_next_next = (op_end < floor_r) ? floor_r : op_end;
          state_next = S_ADD2;
        end
      end

      // round base up and end down to page boundaries
      S_ADD2: begin
        q_next = {1'b0, a_base[ADDR_BITS-1:PAGE_SHIFT]} +
                 (PN_BITS + 1)'(|(a_base & LOW_MASK));
        a_next_next = a_next & ~LOW_MASK;
        state_next = S_ADD3;
      end

      S_ADD3: begin
        a_base_next = {q[PN_BITS-1:0], {PAGE_SHIFT{1'b0}}};
        a_next_next = (a_next > limit_r) ? limit_r : a_next;
        if (q[PN_BITS] || ({q[PN_BITS-1:0], {PAGE_SHIFT{1'b0}}} >= limit_r)) begin
          res_status_next = ST_SKIP;
          state_next = S_DONE;
        end else begin
          state_next = S_ADD4;
        end
      end

      // append the region at the end, then tidy; an unaligned limit can leave
      // less than one page, which is skipped too
      S_ADD4: begin
        if (a_next <= a_base || span[ADDR_BITS-1:PAGE_SHIFT] == '0) begin
          res_status_next = ST_SKIP;
          state_next = S_DONE;
        end else if (count >= CNT_BITS'(MAX_REGIONS)) begin
          res_status_next = ST_FULL;
          state_next = S_DONE;
        end else begin
          ram_we = 1'b1;
          ram_waddr = count[IDX_BITS-1:0];
          ram_wdata.base = a_base[ADDR_BITS-1:PAGE_SHIFT];
          ram_wdata.pages = PAGE_W'(span >> PAGE_SHIFT);
          res_pages_next = PAGE_W'(span >> PAGE_SHIFT);
          count_next = count + 1'b1;
          rd_next = '0;
          wp_next = '0;
          have_next = 1'b0;
          state_next = S_TIDY;
        end
      end

      // first-fit scan, one entry per cycle
      S_SRCH: begin
        if (rd < count) begin
          rd_next = rd + 1'b1;
          dv_next = 1'b1;
        end
        if (dv && ram_rdata.pages >= op_nr) begin
          hit_next = ram_rdata;
          // read data belongs to the address issued in the previous cycle
          hit_idx_next = IDX_BITS'(rd - 1'b1);
          dv_next = 1'b0;
          state_next = S_AWR;
        end else if (!dv && rd == count) begin
          res_status_next = ST_NO_FIT;
          state_next = S_DONE;
        end
      end

      // carve pages off the front of the hit entry
      S_AWR: begin
        ram_we = 1'b1;
        ram_waddr = hit_idx;
        ram_wdata.base = hit.base + PN_BITS'(op_nr);
        ram_wdata.pages = hit.pages - op_nr;
        res_addr_next = {hit.base, {PAGE_SHIFT{1'b0}}};
        rd_next = '0;
        wp_next = '0;
        have_next = 1'b0;
        state_next = S_TIDY;
      end

      // compaction pass: drop empty entries, merge touching ones
      S_TIDY: begin
        if (rd < count) begin
          rd_next = rd + 1'b1;
          dv_next = 1'b1;
        end
        if (dv) begin
          if (ram_rdata.pages != '0) begin
            if (!have) begin
              acc_next = ram_rdata;
              have_next = 1'b1;
            end else if (acc_end == ram_rdata.base && !merge_sum[PAGE_W]) begin
              acc_next.pages = merge_sum[PAGE_W-1:0];
            end else begin
              ram_we = 1'b1;
              wp_next = wp + 1'b1;
              acc_next = ram_rdata;
            end
          end
        end else if (rd == count) begin
          if (have) begin
            ram_we = 1'b1;
            count_next = wp + 1'b1;
          end else begin
            count_next = wp;
          end
          state_next = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid || rsp.ready) begin
          load_out = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      dv <= 1'b0;
      have <= 1'b0;
      out_valid <= 1'b0;
      floor_r <= FLOOR_RESET;
      limit_r <= LIMIT_RESET;
    end else begin
      state <= state_next;
      count <= count_next;
      dv <= dv_next;
      have <= have_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_FLOOR: floor_r <= cfg_data;
          CFG_LIMIT: limit_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    rd <= rd_next;
    wp <= wp_next;
    acc <= acc_next;
    hit <= hit_next;
    hit_idx <= hit_idx_next;
    a_base <= a_base_next;
    a_next <= a_next_next;
    q <= q_next;
    res_status <= res_status_next;
    res_addr <= res_addr_next;
    res_pages <= res_pages_next;
    if (state == S_IDLE && req.valid) begin
      op_mode <= req.mode;
      op_start <= req.region_start;
      op_end <= req.region_end;
      op_type <= req.region_type;
      op_nr <= req.page_request;
    end
    if (load_out) begin
      out_status <= (op_mode == MODE_CLEAR) ? ST_DONE : res_status;
      out_addr <= res_addr;
      out_pages <= res_pages;
    end
  end
endmodule
`default_nettype wire
